// File: rtl/art_pkg.sv
// art_pkg: shared constants, codes and types of the allocation range tracker
// depends on nothing; used by the interfaces, the cells, the scan unit and the top level
package art_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 48;
  localparam int SIZE_W        = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 3;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERRUN  = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // write into one cell while the ring is at rest
  typedef struct packed {
    logic             en;
    logic             load;   // also load base and size
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } cell_wr_t;

  typedef struct packed {
    logic             step;   // head entry is examined this cycle
    logic             first;  // first step of a request
    logic [IDX_W-1:0] idx;    // slot number currently at the head
  } scan_ctl_t;

  typedef struct packed {
    logic              match;      // valid entry with the request base
    logic [IDX_W-1:0]  match_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;   // lowest empty slot
    logic              cand_found;
    logic [ADDR_W-1:0] cand_base;  // greatest base not above the address
    logic [SIZE_W-1:0] cand_size;
  } scan_res_t;

endpackage

// File: rtl/art_req_if.sv
// art_req_if: request channel of the allocation range tracker (valid/ready plus payload)
// depends on art_pkg
interface art_req_if;
  logic                      valid;
  logic                      ready;
  logic [art_pkg::OP_W-1:0]   op;
  logic [art_pkg::ADDR_W-1:0] addr;
  logic [art_pkg::SIZE_W-1:0] size;

  modport source (output valid, output op, output addr, output size, input ready);
  modport sink   (input valid, input op, input addr, input size, output ready);
endinterface

// File: rtl/art_rsp_if.sv
// art_rsp_if: result channel of the allocation range tracker (valid/ready plus payload)
// depends on art_pkg
interface art_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [art_pkg::STATUS_W-1:0] status;
  logic [art_pkg::ADDR_W-1:0]   object_base;
  logic [art_pkg::SIZE_W-1:0]   object_size;

  modport source (output valid, output status, output object_base, output object_size,
                  input ready);
  modport sink   (input valid, input status, input object_base, input object_size,
                  output ready);
endinterface

// File: rtl/art_cell.sv
// art_cell: one table slot of the rotating ring; shifts from its neighbor or takes a write
// depends on art_pkg
module art_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift,
  input  art_pkg::cell_wr_t       wr,
  input  logic [art_pkg::IDX_W-1:0] my_idx,
  input  art_pkg::entry_t         nbr,
  output art_pkg::entry_t         ent
);
  import art_pkg::*;

  logic              valid_r;
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] size_r;
  logic              sel;

  assign sel = wr.en && (wr.idx == my_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= nbr.valid;
    end else if (sel) begin
      valid_r <= wr.ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      base_r <= nbr.base;
      size_r <= nbr.size;
    end else if (sel && wr.load) begin
      base_r <= wr.ent.base;
      size_r <= wr.ent.size;
    end
  end

  assign ent = '{valid: valid_r, base: base_r, size: size_r};

endmodule

// File: rtl/art_scan.sv
// art_scan: comparator at the head of the ring; gathers match, free slot and lookup candidate
// depends on art_pkg
module art_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  art_pkg::scan_ctl_t         ctl,
  input  art_pkg::entry_t            head,
  input  logic [art_pkg::ADDR_W-1:0] addr,
  output art_pkg::scan_res_t         res
);
  import art_pkg::*;

  scan_res_t acc_r;
  scan_res_t cur;
  scan_res_t acc_nxt;
  logic      hit_eq;
  logic      below;

  assign hit_eq = head.valid && (head.base == addr);
  assign below  = head.valid && (head.base <= addr);

  always_comb begin
    cur = acc_r;
    if (ctl.first) begin
      cur = '0;
    end
    acc_nxt = cur;
    if (hit_eq && !cur.match) begin
      acc_nxt.match     = 1'b1;
      acc_nxt.match_idx = ctl.idx;
    end
    if (!head.valid && !cur.free_found) begin
      acc_nxt.free_found = 1'b1;
      acc_nxt.free_idx   = ctl.idx;
    end
    if (below && (!cur.cand_found || (head.base > cur.cand_base))) begin
      acc_nxt.cand_found = 1'b1;
      acc_nxt.cand_base  = head.base;
      acc_nxt.cand_size  = head.size;
    end
  end

  // accumulator, advanced once per examined slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign res = acc_r;

endmodule

// File: rtl/allocation_range_tracker.sv
// allocation_range_tracker: table of allocated address ranges held in a rotating ring of cells
// one request at a time: a new request is taken only after the ring has turned fully past
//   the single comparator at its head and the result has been committed to the output register
// reset: synchronous active-low rst_n empties every slot at once; no clearing pass
// depends on art_pkg, art_req_if, art_rsp_if, art_cell, art_scan
module allocation_range_tracker (
  input  logic          clk,
  input  logic          rst_n,
  art_req_if.sink       in_req,
  art_rsp_if.source     out_rsp
);
  import art_pkg::*;

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r;        // slot number at the ring head
  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SIZE_W-1:0]   size_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   obase_r, obase_nxt;
  logic [SIZE_W-1:0]   osize_r, osize_nxt;

  logic                in_fire;
  logic                commit;
  logic                shift;
  scan_ctl_t           ctl;
  scan_res_t           res;
  cell_wr_t            wr;
  entry_t              ring [TABLE_ENTRIES];

  // lookup bounds, one bit wider so base + size never wraps
  logic [ADDR_W:0]     hi_end;
  logic [ADDR_W:0]     acc_end;

  // new request only between requests; a pending result may still sit in the output register
  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  // commit once the ring is home and the output register can take the result
  assign commit = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign shift  = (state_r == S_SCAN);

  assign ctl.step  = shift;
  assign ctl.first = (cnt_r == '0);
  assign ctl.idx   = cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: if (cnt_r == LAST_IDX) state_nxt = S_DONE;
      S_DONE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cnt_r <= '0;
      end else if (shift) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : IDX_W'(cnt_r + 1'b1);
      end
    end
  end

  // request payload, held for the whole scan
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_req.op;
      addr_r <= in_req.addr;
      size_r <= in_req.size;
    end
  end

  // ring of cells: each cell takes its upper neighbor, the last wraps to slot zero's cell
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    localparam int NXT = (g + 1) % TABLE_ENTRIES;
    art_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (shift),
      .wr     (wr),
      .my_idx (IDX_W'(g)),
      .nbr    (ring[NXT]),
      .ent    (ring[g])
    );
  end

  art_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (ring[0]),
    .addr  (addr_r),
    .res   (res)
  );

  // table update: alloc fills the lowest empty slot, free clears the matching slot
  always_comb begin
    wr           = '0;
    wr.ent.base  = addr_r;
    wr.ent.size  = size_r;
    if (commit && (op_r == OP_ALLOC) && !res.match && res.free_found) begin
      wr.en        = 1'b1;
      wr.load      = 1'b1;
      wr.idx       = res.free_idx;
      wr.ent.valid = 1'b1;
    end else if (commit && (op_r == OP_FREE) && res.match) begin
      wr.en        = 1'b1;
      wr.idx       = res.match_idx;
      wr.ent.valid = 1'b0;
    end
  end

  assign hi_end  = {1'b0, res.cand_base} + (ADDR_W+1)'(res.cand_size);
  assign acc_end = {1'b0, addr_r} + (ADDR_W+1)'(size_r);

  // result of the finished scan
  always_comb begin
    status_nxt = ST_OK;
    obase_nxt  = '0;
    osize_nxt  = '0;
    unique case (op_r)
      OP_ALLOC: begin
        if (res.match) begin
          status_nxt = ST_DUP;
        end else if (!res.free_found) begin
          status_nxt = ST_FULL;
        end
      end
      OP_FREE: begin
        if (!res.match) begin
          status_nxt = ST_UNKNOWN;
        end
      end
      OP_LOOKUP: begin
        // only the nearest base below is tried; past its end is a miss
        if (!res.cand_found || ({1'b0, addr_r} >= hi_end)) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          obase_nxt  = res.cand_base;
          osize_nxt  = res.cand_size;
          status_nxt = (acc_end > hi_end) ? ST_OVERRUN : ST_OK;
        end
      end
      OP_NONE: begin
        status_nxt = ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_nxt;
      obase_r  <= obase_nxt;
      osize_r  <= osize_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.object_base = obase_r;
  assign out_rsp.object_size = osize_r;

endmodule
